FILE: design/iqdfs_pkg.sv
package iqdfs_pkg;

    localparam int unsigned TableAddrBits = 10;
    localparam int unsigned QuarterBits   = TableAddrBits - 2;
    localparam int unsigned QuarterLen    = 1 << QuarterBits;
    localparam int unsigned PhaseBits     = 32;
    localparam int unsigned SampleBits    = 16;
    localparam int unsigned ProdBits      = 33;
    localparam int unsigned SumBits       = 34;
    localparam int unsigned RndBits       = 19;
    localparam logic [63:0] OneQ30        = 64'd1 << 30;
    localparam logic [63:0] HalfPiQ30     = 64'd1686629713;
    localparam logic [63:0] SineMax       = 64'd32767;
    localparam int unsigned TaylorDiv [7] = '{210, 156, 110, 72, 42, 20, 6};

    typedef enum logic [1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_SHIFT_EN   = 2'd1,
        CFG_LINK_UP    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_PASS,
        MODE_ROT
    } t_mode;

    typedef struct packed {
        logic signed [SampleBits-1:0] re;
        logic signed [SampleBits-1:0] im;
        t_mode                        mode;
        logic [TableAddrBits-1:0]     addr;
    } t_mix_item;

    typedef logic [0:QuarterLen][SampleBits-1:0] t_sine_tab;

    // quarter-wave sine in Q1.15, Horner Taylor series in Q30
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] v;
        for (int unsigned j = 0; j <= QuarterLen; j++) begin
            x  = (64'(j) * HalfPiQ30 + 64'(QuarterLen >> 1)) / 64'(QuarterLen);
            x2 = (x * x + (OneQ30 >> 1)) >> 30;
            t  = OneQ30;
            for (int k = 0; k < 7; k++) begin
                p = (x2 * t) >> 30;
                p = p / 64'(TaylorDiv[k]);
                t = (p > OneQ30) ? 64'd0 : OneQ30 - p;
            end
            s = (x * t) >> 30;
            v = (s * SineMax + (OneQ30 >> 1)) >> 30;
            tab[j] = (v > SineMax) ? SampleBits'(SineMax) : v[SampleBits-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SineTab = build_sine_tab();

    // round half away from zero, drop 15 fraction bits, clamp to int16
    function automatic logic signed [SampleBits-1:0] round_sat(input logic signed [SumBits-1:0] p);
        logic               neg;
        logic [SumBits-1:0] mag;
        logic [SumBits-1:0] rsum;
        logic [RndBits-1:0] rnd;
        logic signed [SampleBits-1:0] res;
        neg  = p[SumBits-1];
        mag  = neg ? SumBits'(-p) : SumBits'(p);
        rsum = mag + SumBits'(1 << 14);
        rnd  = rsum[15 +: RndBits];
        if (neg) begin
            res = (rnd > RndBits'(32768)) ? 16'sh8000 : SampleBits'(-rnd);
        end else begin
            res = (rnd > RndBits'(32767)) ? 16'sh7fff : rnd[SampleBits-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/iqdfs_in_if.sv
interface iqdfs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               channel_start;
    logic               first_channel;

    modport source (output valid, sample_re, sample_im, channel_start, first_channel,
                    input ready);
    modport sink   (input valid, sample_re, sample_im, channel_start, first_channel,
                    output ready);
endinterface

FILE: design/iqdfs_out_if.sv
interface iqdfs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;

    modport source (output valid, out_re, out_im, input ready);
    modport sink   (input valid, out_re, out_im, output ready);
endinterface

FILE: design/iqdfs_mixer.sv
module iqdfs_mixer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  iqdfs_pkg::t_mix_item  i_item,
    iqdfs_out_if.source           o_out
);
    import iqdfs_pkg::*;

    logic rdy1, rdy2, rdy3, rdy4;

    logic      r_v1, r_v2, r_v3, r_v4;
    t_mix_item r1_item;

    logic signed [SampleBits-1:0] r2_re, r2_im;
    logic signed [SampleBits:0]   r2_sin, r2_cos;
    t_mode                        r2_mode;
    logic signed [SampleBits:0]   n_sin, n_cos;

    logic signed [SampleBits-1:0] r3_re, r3_im;
    logic signed [ProdBits-1:0]   r3_rc, r3_is, r3_rs, r3_ic;
    t_mode                        r3_mode;

    logic signed [SumBits-1:0]    n_sum_re, n_sum_im;
    logic signed [SampleBits-1:0] n_out_re, n_out_im;
    logic signed [SampleBits-1:0] r_out_re, r_out_im;

    logic [1:0]             quad;
    logic [QuarterBits-1:0] j;
    logic [QuarterBits:0]   idx_lo, idx_hi;
    logic signed [SampleBits:0] tab_lo, tab_hi;

    assign rdy4    = !r_v4 || o_out.ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign quad   = r1_item.addr[TableAddrBits-1 -: 2];
    assign j      = r1_item.addr[QuarterBits-1:0];
    assign idx_lo = {1'b0, j};
    assign idx_hi = (QuarterBits+1)'(QuarterLen) - idx_lo;
    assign tab_lo = $signed({1'b0, SineTab[idx_lo]});
    assign tab_hi = $signed({1'b0, SineTab[idx_hi]});

    always_comb begin
        unique case (quad)
            2'd0: begin
                n_sin = tab_lo;
                n_cos = tab_hi;
            end
            2'd1: begin
                n_sin = tab_hi;
                n_cos = -tab_lo;
            end
            2'd2: begin
                n_sin = -tab_lo;
                n_cos = -tab_hi;
            end
            default: begin
                n_sin = -tab_hi;
                n_cos = tab_lo;
            end
        endcase
    end

    always_comb begin
        n_sum_re = SumBits'(r3_rc) - SumBits'(r3_is);
        n_sum_im = SumBits'(r3_rs) + SumBits'(r3_ic);
        unique case (r3_mode)
            MODE_ZERO: begin
                n_out_re = '0;
                n_out_im = '0;
            end
            MODE_ROT: begin
                n_out_re = round_sat(n_sum_re);
                n_out_im = round_sat(n_sum_im);
            end
            default: begin
                n_out_re = r3_re;
                n_out_im = r3_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_item <= i_item;
        end
        if (rdy2) begin
            r2_re   <= r1_item.re;
            r2_im   <= r1_item.im;
            r2_mode <= r1_item.mode;
            r2_sin  <= n_sin;
            r2_cos  <= n_cos;
        end
        if (rdy3) begin
            r3_re   <= r2_re;
            r3_im   <= r2_im;
            r3_mode <= r2_mode;
            r3_rc   <= ProdBits'(r2_re) * ProdBits'(r2_cos);
            r3_is   <= ProdBits'(r2_im) * ProdBits'(r2_sin);
            r3_rs   <= ProdBits'(r2_re) * ProdBits'(r2_sin);
            r3_ic   <= ProdBits'(r2_im) * ProdBits'(r2_cos);
        end
        if (rdy4) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
        end
    end

    assign o_out.valid  = r_v4;
    assign o_out.out_re = r_out_re;
    assign o_out.out_im = r_out_im;

endmodule

FILE: design/iq_doppler_frequency_shifter.sv
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   sample_re, sample_im, channel_start, first_channel
// o_out     out  valid/ready   out_re, out_im
// cfg       in   i_cfg_wr_en   i_cfg_idx, i_cfg_data
//
// One sample per clock unless the output stalls; the result is registered in every stage.
// The phase accumulator updates at the input transfer when active, so it sets the rate.
// Four pipeline stages (input, table lookup, multipliers, round/output) each
// fill a bubble while the output is stalled.
// Synchronous active-low reset clears the phase, step and enable; link is up.
module iq_doppler_frequency_shifter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    iqdfs_in_if.sink    i_in,
    iqdfs_out_if.source o_out
);
    import iqdfs_pkg::*;

    logic [PhaseBits-1:0] r_phase_step;
    logic                 r_shift_en;
    logic                 r_link_up;
    logic [PhaseBits-1:0] r_phase_acc;
    logic [PhaseBits-1:0] r_base_phase;

    logic                 mix_ready;
    logic                 xfer;
    logic                 active;
    logic [PhaseBits-1:0] n_phase_eff;
    logic [PhaseBits-1:0] n_phase_acc;
    t_mix_item            item;

    assign i_in.ready = mix_ready;
    assign xfer       = i_in.valid && mix_ready;
    assign active     = r_link_up && r_shift_en;

    always_comb begin
        n_phase_eff = r_phase_acc;
        if (i_in.channel_start && !i_in.first_channel) begin
            n_phase_eff = r_base_phase;
        end
        n_phase_acc = n_phase_eff + r_phase_step;

        item.re   = i_in.sample_re;
        item.im   = i_in.sample_im;
        item.addr = n_phase_eff[PhaseBits-1 -: TableAddrBits];
        priority if (!r_link_up) begin
            item.mode = MODE_ZERO;
        end else if (!r_shift_en || r_phase_step == '0) begin
            item.mode = MODE_PASS;
        end else begin
            item.mode = MODE_ROT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_shift_en   <= 1'b0;
            r_link_up    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_SHIFT_EN:   r_shift_en   <= i_cfg_data[0];
                CFG_LINK_UP:    r_link_up    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // save or rewind on channel start, then advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= '0;
            r_base_phase <= '0;
        end else if (xfer && active) begin
            if (i_in.channel_start && i_in.first_channel) begin
                r_base_phase <= r_phase_acc;
            end
            r_phase_acc <= n_phase_acc;
        end
    end

    iqdfs_mixer u_mixer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (mix_ready),
        .i_item  (item),
        .o_out   (o_out)
    );

endmodule

FILE: test/iqdfs_shift_check.sv
`timescale 1ns / 1ps

module iqdfs_shift_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    iqdfs_in_if         in_ch,
    iqdfs_out_if        out_ch,
    output int          o_errors,
    output int          o_pending
);

    localparam int          AddrBits  = iqdfs_pkg::TableAddrBits;
    localparam int          QBits     = AddrBits - 2;
    localparam int          QLen      = 1 << QBits;
    localparam logic [63:0] UnitQ30   = 64'd1 << 30;
    localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } iq_t;

    logic [15:0] sine_q [0:QLen];
    iq_t         shifted_q [$];
    logic [31:0] phase;
    logic [31:0] base_phase;
    logic [31:0] step_reg;
    logic        en_reg;
    logic        link_reg;
    int          mismatches = 0;

    initial begin : build_sine
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] v;
        for (int j = 0; j <= QLen; j++) begin
            x  = (64'(j) * PiHalfQ30 + 64'(QLen / 2)) / 64'(QLen);
            x2 = (x * x + (UnitQ30 >> 1)) >> 30;
            t  = UnitQ30;
            for (int k = 7; k >= 1; k--) begin
                p = ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
                t = (p > UnitQ30) ? 64'd0 : UnitQ30 - p;
            end
            s = (x * t) >> 30;
            v = (s * 64'd32767 + (UnitQ30 >> 1)) >> 30;
            sine_q[j] = (v > 64'd32767) ? 16'd32767 : v[15:0];
        end
    end

    function automatic logic signed [15:0] scale_round(input longint acc);
        longint mag;
        longint r;
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + 16384) >>> 15;
        if (mag > 40000) mag = 40000;
        r = (acc < 0) ? -mag : mag;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // advances the phase state as a side effect
    function automatic iq_t doppler_shift(input logic signed [15:0] re, input logic signed [15:0] im,
                                          input logic st, input logic fc);
        iq_t                 r;
        logic [AddrBits-1:0] addr;
        int                  ji;
        int                  lo;
        int                  hi;
        int                  c;
        int                  s;
        r.re = re;
        r.im = im;
        if (!link_reg) begin
            r.re = '0;
            r.im = '0;
            return r;
        end
        if (!en_reg) return r;
        if (st) begin
            if (fc) base_phase = phase;
            else phase = base_phase;
        end
        if (step_reg == 32'd0) return r;
        addr = phase[31 -: AddrBits];
        ji   = int'(addr[QBits-1:0]);
        lo   = int'(sine_q[ji]);
        hi   = int'(sine_q[QLen - ji]);
        case (addr[AddrBits-1 -: 2])
            2'd0: begin
                s = lo;
                c = hi;
            end
            2'd1: begin
                s = hi;
                c = -lo;
            end
            2'd2: begin
                s = -lo;
                c = -hi;
            end
            default: begin
                s = -hi;
                c = lo;
            end
        endcase
        r.re  = scale_round(longint'(re) * c - longint'(im) * s);
        r.im  = scale_round(longint'(re) * s + longint'(im) * c);
        phase = phase + step_reg;
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        iq_t want;
        if (!i_rst_n) begin
            phase      = '0;
            base_phase = '0;
            step_reg   = '0;
            en_reg     = 1'b0;
            link_reg   = 1'b1;
            shifted_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    iqdfs_pkg::CFG_PHASE_STEP: step_reg = i_cfg_data;
                    iqdfs_pkg::CFG_SHIFT_EN:   en_reg   = i_cfg_data[0];
                    iqdfs_pkg::CFG_LINK_UP:    link_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (shifted_q.size() == 0) begin
                    $error("unexpected output transfer: out_re %0d out_im %0d",
                           out_ch.out_re, out_ch.out_im);
                    mismatches++;
                end else begin
                    want = shifted_q.pop_front();
                    if (out_ch.out_re !== want.re) begin
                        $error("out_re: expected %0d, actual %0d", want.re, out_ch.out_re);
                        mismatches++;
                    end
                    if (out_ch.out_im !== want.im) begin
                        $error("out_im: expected %0d, actual %0d", want.im, out_ch.out_im);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                shifted_q.push_back(doppler_shift(in_ch.sample_re, in_ch.sample_im,
                                                  in_ch.channel_start, in_ch.first_channel));
            end
        end
        o_pending <= shifted_q.size();
        o_errors  <= mismatches;
    end

endmodule

FILE: test/iq_doppler_frequency_shifter_tb.sv
`timescale 1ns / 1ps

module iq_doppler_frequency_shifter_tb;

    import iqdfs_pkg::*;

    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
    localparam int         HOLD_CYCLES   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        hold_start = 1'b0;
    int          hold_left = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mix_errors;
    int          mix_pending;

    iqdfs_in_if  in_ch ();
    iqdfs_out_if out_ch ();

    iq_doppler_frequency_shifter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    iqdfs_shift_check u_shift_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (mix_errors),
        .o_pending  (mix_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hold off the output for a counted stretch, else stall at random
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sd0;
            3:       return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic st, input logic fc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.sample_re     <= re;
        in_ch.sample_im     <= im;
        in_ch.channel_start <= st;
        in_ch.first_channel <= fc;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (mix_pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // well-formed blocks of channels mostly, loose restart flags otherwise
    task automatic send_traffic(input int n);
        int done_items;
        int chans;
        int len;
        done_items = 0;
        while (done_items < n) begin
            if ($urandom_range(99) < 80) begin
                chans = $urandom_range(4, 1);
                len   = $urandom_range(8, 1);
                for (int ch = 0; ch < chans; ch++) begin
                    for (int k = 0; k < len; k++) begin
                        send_sample(rand_sample(), rand_sample(), k == 0, ch == 0);
                    end
                end
                done_items += chans * len;
            end else begin
                send_sample(rand_sample(), rand_sample(), 1'($urandom), 1'($urandom));
                done_items++;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] step, input logic en, input logic link,
                             input int s_idle, input int r_stall, input bit hold, input int n);
        wait_idle();
        send_idle_pct = s_idle;
        recv_stall_pct <= r_stall;
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_SHIFT_EN, {31'($urandom), en});
        write_reg(CFG_LINK_UP, {31'($urandom), link});
        if (hold) begin
            hold_start <= 1'b1;
            @(posedge i_clk);
            hold_start <= 1'b0;
        end
        send_traffic(n);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.sample_re     = '0;
        in_ch.sample_im     = '0;
        in_ch.channel_start = 1'b0;
        in_ch.first_channel = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass through at reset settings
        send_sample(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
        send_sample(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
        send_sample(16'sd0, -16'sd1, 1'b1, 1'b0);

        // eighth-turn steps through all quadrants, both saturation directions
        wait_idle();
        write_reg(CFG_PHASE_STEP, 32'h2000_0000);
        write_reg(CFG_SHIFT_EN, 32'd1);
        for (int k = 0; k < 8; k++) begin
            send_sample(k[0] ? 16'sh8000 : 16'sh7fff, k[0] ? 16'sh7fff : 16'sh8000,
                        k == 0, k == 0);
        end
        send_sample(16'sd16384, 16'sd0, 1'b1, 1'b0);
        send_sample(16'sd1, 16'sd1, 1'b0, 1'b0);
        send_sample(-16'sd1, 16'sd1, 1'b1, 1'b1);

        wait_idle();
        write_reg(CFG_PHASE_STEP, 32'hffff_ffff);
        write_reg(CFG_IDX_SPARE, 32'($urandom));
        send_sample(16'sd12345, -16'sd321, 1'b0, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);

        // zero step, then link down
        wait_idle();
        write_reg(CFG_PHASE_STEP, 32'd0);
        send_sample(16'sd100, -16'sd100, 1'b1, 1'b1);
        send_sample(16'sd5, 16'sd5, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_LINK_UP, 32'hffff_fffe);
        send_sample(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
        send_sample(-16'sd5, 16'sd7, 1'b0, 1'b0);

        run_phase(32'($urandom), 1'b1, 1'b1, 0, 0, 1'b0, 70);
        run_phase(32'h8000_0000, 1'b1, 1'b1, 65, 0, 1'b0, 60);
        run_phase(32'h7fff_ffff, 1'b1, 1'b1, 0, 65, 1'b0, 60);
        run_phase(32'($urandom_range(1 << 20)), 1'b1, 1'b1, 17, 17, 1'b0, 60);
        run_phase(32'($urandom), 1'b0, 1'b1, 17, 17, 1'b0, 30);
        run_phase(32'($urandom), 1'b1, 1'b0, 0, 0, 1'b0, 30);
        run_phase(32'd0, 1'b1, 1'b1, 17, 17, 1'b0, 30);
        run_phase(32'd1, 1'b1, 1'b1, 0, 0, 1'b0, 30);
        run_phase(32'($urandom), 1'b1, 1'b1, 0, 0, 1'b1, 50);
        run_phase(32'hffff_ffff, 1'b1, 1'b1, 17, 17, 1'b0, 40);
        wait_idle();

        if (mix_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
